### rtl/core/fbpa_pkg.sv
// shared types, codes and defaults of the fixed block pool allocator
package fbpa_pkg;

	// default pool geometry
	localparam int unsigned DefBlockCount  = 16;
	localparam int unsigned DefBlockStride = 16;

	// request codes
	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	// result status codes
	localparam logic [2:0] STATUS_OK        = 3'd0;
	localparam logic [2:0] STATUS_EXHAUSTED = 3'd1;
	localparam logic [2:0] STATUS_RANGE     = 3'd2;
	localparam logic [2:0] STATUS_ALIGN     = 3'd3;
	localparam logic [2:0] STATUS_NOT_ALLOC = 3'd4;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ALLOC,
		ST_DIV,
		ST_CHECK,
		ST_FREE
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;        // capture the free offset
		logic divide;      // offset to block index
		logic check;       // range, alignment, mark read
		logic alloc_done;  // pop head, load result
		logic free_done;   // push block, load result
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic out_free;    // result register can take a new result
	} stat_t;

endpackage

### rtl/core/fbpa_ctrl.sv
// request sequencer of the fixed block pool allocator
module fbpa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                func,
	input  fbpa_pkg::stat_t     stat,
	output logic                in_ready,
	output fbpa_pkg::cmd_t      cmd
);

	fbpa_pkg::state_t state_q;
	fbpa_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fbpa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			fbpa_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = (func == fbpa_pkg::FUNC_FREE) ? fbpa_pkg::ST_DIV
					                                         : fbpa_pkg::ST_ALLOC;
				end
			end
			fbpa_pkg::ST_ALLOC: begin
				if (stat.out_free) begin
					cmd.alloc_done = 1'b1;
					state_d        = fbpa_pkg::ST_IDLE;
				end
			end
			fbpa_pkg::ST_DIV: begin
				cmd.divide = 1'b1;
				state_d    = fbpa_pkg::ST_CHECK;
			end
			fbpa_pkg::ST_CHECK: begin
				cmd.check = 1'b1;
				state_d   = fbpa_pkg::ST_FREE;
			end
			fbpa_pkg::ST_FREE: begin
				if (stat.out_free) begin
					cmd.free_done = 1'b1;
					state_d       = fbpa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fbpa_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/core/fbpa_dpath.sv
// link table, mark table, head and result register of the block pool
module fbpa_dpath #(
	parameter int unsigned BLOCK_COUNT  = fbpa_pkg::DefBlockCount,
	parameter int unsigned BLOCK_STRIDE = fbpa_pkg::DefBlockStride
) (
	input  logic               clk,
	input  logic               arst_n,
	input  fbpa_pkg::cmd_t     cmd,
	input  logic [15:0]        free_offset,
	input  logic               out_ready,
	output fbpa_pkg::stat_t    stat,
	output logic               out_valid,
	output logic [2:0]         status,
	output logic [15:0]        alloc_offset
);

	localparam int unsigned IdxW = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
	localparam int unsigned PtrW = $clog2(BLOCK_COUNT + 1);
	localparam int unsigned LastStart = (BLOCK_COUNT - 1) * BLOCK_STRIDE;
	// reciprocal of the stride, exact for any 16-bit offset
	localparam int unsigned RecipShift = 16 + $clog2(BLOCK_STRIDE);
	localparam logic [17:0] RecipMult =
		18'(((64'd1 << RecipShift) + 64'(BLOCK_STRIDE) - 64'd1) / 64'(BLOCK_STRIDE));

	logic [PtrW-1:0] link_mem [BLOCK_COUNT];
	logic            mark_mem [BLOCK_COUNT];

	logic [15:0]     offs_q;
	logic [PtrW-1:0] head_q;
	logic [PtrW-1:0] wmark_q;
	logic [PtrW-1:0] link_rd_q;
	logic            mark_rd_q;
	logic [15:0]     quo_s1;
	logic [IdxW-1:0] blk_s2;
	logic [2:0]      err_s2;
	logic            untouched_s2;
	logic            out_valid_q;
	logic [2:0]      status_q;
	logic [15:0]     alloc_offset_q;

	logic [33:0]     recip_prod;
	logic [33:0]     quo_full;
	logic [31:0]     back_prod;
	logic [31:0]     head_prod;
	logic            head_null;
	logic            head_fresh;
	logic [PtrW-1:0] head_next;
	logic            free_ok;
	logic [2:0]      free_status;

	assign recip_prod = 34'(offs_q) * 34'(RecipMult);
	assign quo_full   = recip_prod >> RecipShift;
	assign back_prod  = 32'(quo_s1) * 32'(BLOCK_STRIDE);
	assign head_prod  = 32'(head_q) * 32'(BLOCK_STRIDE);

	// blocks at or above the high-water mark still hold their reset chain
	assign head_null  = (head_q == PtrW'(BLOCK_COUNT));
	assign head_fresh = (head_q == wmark_q);
	assign head_next  = head_fresh ? PtrW'(head_q + 1'b1) : link_rd_q;

	assign free_ok     = (err_s2 == fbpa_pkg::STATUS_OK) && !untouched_s2 && mark_rd_q;
	assign free_status = (err_s2 != fbpa_pkg::STATUS_OK) ? err_s2 :
	                     free_ok ? fbpa_pkg::STATUS_OK : fbpa_pkg::STATUS_NOT_ALLOC;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			offs_q <= free_offset;
		end
		link_rd_q <= link_mem[head_q[IdxW-1:0]];
		if (cmd.divide) begin
			quo_s1 <= quo_full[15:0];
		end
		if (cmd.check) begin
			blk_s2       <= quo_s1[IdxW-1:0];
			untouched_s2 <= (quo_s1 >= 16'(wmark_q));
			mark_rd_q    <= mark_mem[quo_s1[IdxW-1:0]];
			if (32'(offs_q) > LastStart) begin
				err_s2 <= fbpa_pkg::STATUS_RANGE;
			end else if (back_prod != 32'(offs_q)) begin
				err_s2 <= fbpa_pkg::STATUS_ALIGN;
			end else begin
				err_s2 <= fbpa_pkg::STATUS_OK;
			end
		end
		if (cmd.alloc_done && !head_null) begin
			mark_mem[head_q[IdxW-1:0]] <= 1'b1;
		end
		if (cmd.free_done && free_ok) begin
			mark_mem[blk_s2] <= 1'b0;
			link_mem[blk_s2] <= head_q;
		end
		if (cmd.alloc_done) begin
			status_q       <= head_null ? fbpa_pkg::STATUS_EXHAUSTED : fbpa_pkg::STATUS_OK;
			alloc_offset_q <= head_null ? 16'd0 : head_prod[15:0];
		end else if (cmd.free_done) begin
			status_q       <= free_status;
			alloc_offset_q <= 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			wmark_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.alloc_done && !head_null) begin
				head_q <= head_next;
				if (head_fresh) begin
					wmark_q <= PtrW'(wmark_q + 1'b1);
				end
			end else if (cmd.free_done && free_ok) begin
				head_q <= PtrW'(blk_s2);
			end
			if (cmd.alloc_done || cmd.free_done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign alloc_offset  = alloc_offset_q;

endmodule

### rtl/core/fixed_block_pool_allocator.sv
// top level of the fixed block pool allocator
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------
//  request | in        | in_valid / in_ready   | func, free_offset
//  result  | out       | out_valid / out_ready | status, alloc_offset
//
// in an allocate the link table read at the head is registered at the request
// transfer; the pop and the result load follow once the result register is free
// a free runs a reciprocal multiply to a block index, a back multiply for the
// alignment check plus the registered mark table read, then the push
// no clearing pass after reset: a high-water counter marks blocks still in
// their reset chain, so requests are taken from the first cycle out of reset
// a result waiting in the output register does not stop the next request;
// only a second result finding the register still full stalls the sequencer
module fixed_block_pool_allocator #(
	parameter int unsigned BLOCK_COUNT  = fbpa_pkg::DefBlockCount,
	parameter int unsigned BLOCK_STRIDE = fbpa_pkg::DefBlockStride
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [15:0] free_offset,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [15:0] alloc_offset
);

	fbpa_pkg::cmd_t  cmd;
	fbpa_pkg::stat_t stat;

	// sequencer: one request at a time, branches on the request code
	fbpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.func     (func),
		.stat     (stat),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	// free list storage, offset checks and the result register
	fbpa_dpath #(
		.BLOCK_COUNT  (BLOCK_COUNT),
		.BLOCK_STRIDE (BLOCK_STRIDE)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.free_offset  (free_offset),
		.out_ready    (out_ready),
		.stat         (stat),
		.out_valid    (out_valid),
		.status       (status),
		.alloc_offset (alloc_offset)
	);

	// only one kind of commit per cycle
	a_one_commit: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.alloc_done && cmd.free_done))
		else $error("allocate and free commit in the same cycle");

	// a commit never overwrites a result that has not been transferred
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.alloc_done || cmd.free_done) |-> (!out_valid || out_ready))
		else $error("result register overwritten before transfer");

	// a result only appears after a commit
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.alloc_done || cmd.free_done))
		else $error("result appeared without a commit");

	// no request transfer while a free is being checked
	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.divide || cmd.check) |-> !in_ready)
		else $error("request taken while a free is in progress");

endmodule

### tb/sv/fixed_block_pool_allocator_tb.sv
// self-checking testbench for the fixed block pool allocator
module fixed_block_pool_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// pool geometry, the block runs at its defaults
	localparam int unsigned NBLK   = fbpa_pkg::DefBlockCount;
	localparam int unsigned STRIDE = fbpa_pkg::DefBlockStride;
	localparam int unsigned HW     = $clog2(NBLK + 1);
	// byte offset of the last block; anything above it is out of range
	localparam logic [15:0] LAST_START = 16'((NBLK - 1) * STRIDE);
	localparam int RAND_ITEMS = 650;

	// one expected result
	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] offset;
	} pool_result_t;

	// one directed row: request, repeat count, and the result where it is obvious
	typedef struct packed {
		logic        f;
		logic [15:0] offs;
		logic [10:0] reps;
		logic        typed;
		logic [2:0]  st;
		logic [15:0] ao;
	} dir_row_t;

	localparam int DIR_N = 14;
	localparam dir_row_t DIR_ROWS [DIR_N] = '{
		// first allocate out of reset gets block zero
		'{fbpa_pkg::FUNC_ALLOC, 16'h0000, 11'd1, 1'b1, fbpa_pkg::STATUS_OK, 16'h0000},
		'{fbpa_pkg::FUNC_FREE, 16'h0000, 11'd1, 1'b1, fbpa_pkg::STATUS_OK, 16'h0000},
		// double free of block zero
		'{fbpa_pkg::FUNC_FREE, 16'h0000, 11'd1, 1'b1, fbpa_pkg::STATUS_NOT_ALLOC, 16'h0000},
		// largest offset, then one byte past the last block
		'{fbpa_pkg::FUNC_FREE, 16'hFFFF, 11'd1, 1'b1, fbpa_pkg::STATUS_RANGE, 16'h0000},
		'{fbpa_pkg::FUNC_FREE, LAST_START + 16'd1, 11'd1, 1'b1, fbpa_pkg::STATUS_RANGE,
			16'h0000},
		// offset between blocks
		'{fbpa_pkg::FUNC_FREE, 16'h0001, 11'd1, 1'b1, fbpa_pkg::STATUS_ALIGN, 16'h0000},
		// last block is still free
		'{fbpa_pkg::FUNC_FREE, LAST_START, 11'd1, 1'b1, fbpa_pkg::STATUS_NOT_ALLOC,
			16'h0000},
		// offset field must be ignored on allocate
		'{fbpa_pkg::FUNC_ALLOC, 16'hFFFF, 11'd1, 1'b0, fbpa_pkg::STATUS_OK, 16'h0000},
		// drain the rest of the pool
		'{fbpa_pkg::FUNC_ALLOC, 16'h5A5A, 11'(NBLK - 1), 1'b0, fbpa_pkg::STATUS_OK, 16'h0000},
		// empty pool
		'{fbpa_pkg::FUNC_ALLOC, 16'h0000, 11'd1, 1'b1, fbpa_pkg::STATUS_EXHAUSTED, 16'h0000},
		// push last then first, pops must come back in reverse order
		'{fbpa_pkg::FUNC_FREE, LAST_START, 11'd1, 1'b0, fbpa_pkg::STATUS_OK, 16'h0000},
		'{fbpa_pkg::FUNC_FREE, 16'h0000, 11'd1, 1'b0, fbpa_pkg::STATUS_OK, 16'h0000},
		'{fbpa_pkg::FUNC_ALLOC, 16'hFFFF, 11'd1, 1'b0, fbpa_pkg::STATUS_OK, 16'h0000},
		'{fbpa_pkg::FUNC_ALLOC, 16'h0000, 11'd1, 1'b0, fbpa_pkg::STATUS_OK, 16'h0000}
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        func;
	logic [15:0] free_offset;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  status;
	logic [15:0] alloc_offset;

	// predictor copy of the pool
	logic [HW-1:0] link_next [NBLK];
	logic          block_taken [NBLK];
	logic [HW-1:0] free_head;

	// results still owed by the block, oldest first
	pool_result_t pending_results [$];
	int           pool_errors;

	// runs of back-to-back transfers on each side
	bit in_burst;
	bit out_burst;

	fixed_block_pool_allocator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.free_offset  (free_offset),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.alloc_offset (alloc_offset)
	);

	always #5 clk = ~clk;

	// fresh pool: chain 0 -> 1 -> ... -> null, nothing taken
	function automatic void pool_clear();
		for (int i = 0; i < NBLK; i++) begin
			link_next[i]   = HW'(i + 1);
			block_taken[i] = 1'b0;
		end
		free_head = '0;
	endfunction

	// apply one request to the predictor and return what the block must answer
	function automatic pool_result_t pool_predict(input logic f, input logic [15:0] offs);
		pool_result_t res;
		int unsigned  blk;
		res.status = fbpa_pkg::STATUS_OK;
		res.offset = '0;
		if (f == fbpa_pkg::FUNC_ALLOC) begin
			if (free_head >= NBLK) begin
				res.status = fbpa_pkg::STATUS_EXHAUSTED;
			end else begin
				blk              = free_head;
				free_head        = link_next[blk];
				block_taken[blk] = 1'b1;
				res.offset       = 16'(blk * STRIDE);
			end
		end else if (offs > LAST_START) begin
			res.status = fbpa_pkg::STATUS_RANGE;
		end else if ((offs % STRIDE) != 0) begin
			res.status = fbpa_pkg::STATUS_ALIGN;
		end else begin
			blk = offs / STRIDE;
			if (blk >= NBLK || !block_taken[blk]) begin
				res.status = fbpa_pkg::STATUS_NOT_ALLOC;
			end else begin
				block_taken[blk] = 1'b0;
				link_next[blk]   = free_head;
				free_head        = HW'(blk);
			end
		end
		return res;
	endfunction

	// random block that is taken (or free), -1 if there is none
	function automatic int pick_block(input logic want_taken);
		int unsigned start;
		int unsigned b;
		start = $urandom_range(0, NBLK - 1);
		for (int i = 0; i < NBLK; i++) begin
			b = (start + i) % NBLK;
			if (block_taken[b] == want_taken)
				return b;
		end
		return -1;
	endfunction

	function automatic int idle_draw(input bit no_idle);
		return no_idle ? 0 : $urandom_range(0, 6);
	endfunction

	// one request transfer; entered and left at a falling edge
	// typed rows queue their fixed answer, all others the predicted one
	task automatic send_request(input logic f, input logic [15:0] offs,
			input logic typed, input pool_result_t fixed_res);
		int           gap;
		pool_result_t res;
		if ($urandom_range(0, 15) == 0)
			in_burst = !in_burst;
		gap = idle_draw(in_burst);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    = 1'b1;
		func        = f;
		free_offset = offs;
		do @(posedge clk); while (!in_ready);
		res = pool_predict(f, offs);
		pending_results.push_back(typed ? fixed_res : res);
		@(negedge clk);
	endtask

	// stimulus
	initial begin
		int           idx;
		int           r;
		int           fill_left;
		bit           fill_phase;
		logic         f;
		logic [15:0]  offs;
		pool_result_t fixed_res;

		clk         = 1'b0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		func        = fbpa_pkg::FUNC_ALLOC;
		free_offset = '0;
		in_burst    = 1'b0;
		pool_errors = 0;
		pool_clear();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed rows
		for (int i = 0; i < DIR_N; i++) begin
			fixed_res.status = DIR_ROWS[i].st;
			fixed_res.offset = DIR_ROWS[i].ao;
			for (int k = 0; k < DIR_ROWS[i].reps; k++)
				send_request(DIR_ROWS[i].f, DIR_ROWS[i].offs, DIR_ROWS[i].typed, fixed_res);
		end

		// random part: mostly well-formed alloc and free traffic that swings
		// between filling and draining the pool, with broken requests mixed in
		fill_phase = 1'b1;
		fill_left  = $urandom_range(20, 60);
		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (fill_left == 0) begin
				fill_phase = !fill_phase;
				fill_left  = $urandom_range(20, 60);
			end
			fill_left--;
			r    = $urandom_range(0, 99);
			f    = fbpa_pkg::FUNC_FREE;
			offs = 16'($urandom);
			if (r < 8) begin
				// any offset at all
			end else if (r < 12) begin
				// inside the pool but between block starts
				offs = 16'($urandom_range(0, NBLK - 1) * STRIDE + $urandom_range(1, STRIDE - 1));
			end else if (r < 15) begin
				// double free
				idx = pick_block(1'b0);
				if (idx < 0)
					f = fbpa_pkg::FUNC_ALLOC;
				else
					offs = 16'(idx * STRIDE);
			end else if (r < 17) begin
				// just past the last block
				offs = LAST_START + 16'($urandom_range(1, 64));
			end else if ($urandom_range(0, 99) < (fill_phase ? 75 : 25)) begin
				f = fbpa_pkg::FUNC_ALLOC;
			end else begin
				idx = pick_block(1'b1);
				if (idx < 0)
					f = fbpa_pkg::FUNC_ALLOC;
				else
					offs = 16'(idx * STRIDE);
			end
			send_request(f, offs, 1'b0, fixed_res);
		end
		in_valid = 1'b0;

		// drain, then a quiet stretch to catch stray results
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (pool_errors == 0)
			$display("fixed_block_pool_allocator_tb: done, clean");
		else
			$display("fixed_block_pool_allocator_tb: done, errors");
		$finish;
	end

	// result side: random stalls, check each transfer against the oldest expectation
	initial begin
		int           gap;
		pool_result_t want;
		out_ready = 1'b0;
		out_burst = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 15) == 0)
				out_burst = !out_burst;
			gap = idle_draw(out_burst);
			if (gap > 0) begin
				out_ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, status %0d offset %0d",
					$realtime, status, alloc_offset);
				pool_errors++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) begin
					$display("%0t: status expected %0d actual %0d",
						$realtime, want.status, status);
					pool_errors++;
				end
				if (alloc_offset !== want.offset) begin
					$display("%0t: alloc_offset expected %0d actual %0d",
						$realtime, want.offset, alloc_offset);
					pool_errors++;
				end
			end
			@(negedge clk);
		end
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("fixed_block_pool_allocator_tb: done, errors");
		$finish;
	end

endmodule
